@@ src/mtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_pkg - shared types and constants for the three-point Mobius map
// Register indexes, default widths, multiplier digit size and the side-band
// structs that travel down the pipeline with each transaction.
// ----------------------------------------------------------------------------
package mtp_pkg;

    // Default number format: Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Digit width of the digit-serial multipliers
    localparam int MUL_DIGIT = 17;

    // Configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_RE = 3'd0,
        REG_ZERO_IM = 3'd1,
        REG_ONE_RE  = 3'd2,
        REG_ONE_IM  = 3'd3,
        REG_INF_RE  = 3'd4,
        REG_INF_IM  = 3'd5
    } mtp_reg_idx_t;

    // Per-quotient tag carried through the divider cells
    typedef struct packed {
        logic neg;   // quotient is negative
        logic big;   // quotient already known to be out of range
    } mtp_tag_t;

    // Per-transaction side-band from the numerator/denominator stage
    typedef struct packed {
        logic inf;    // denominator is exactly zero
        logic pos_r;  // real part of N strictly positive
        logic pos_i;  // imaginary part of N strictly positive
        logic sn_r;   // sign of Nr
        logic sn_i;   // sign of Ni
        logic sm_r;   // sign of Mr
        logic sm_i;   // sign of Mi
    } mtp_side_t;

endpackage
`default_nettype wire

@@ src/mobius_transform_three_points_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mobius_transform_three_points_core - Mobius map through three points
// Maps w to (w-z0)(z1-z2) / ((w-z2)(z1-z0)) in signed fixed point, with
// round-to-nearest, saturation and a zero-denominator code.
// ----------------------------------------------------------------------------
// One point is taken on every cycle that start is high; busy stays low, so
// there is never a wait. Each transaction comes back on done in order, one
// per cycle, after the difference, product, sum and magnitude stages, the
// digit-serial multipliers, the numerator stage, the divider input register,
// the row of DATA_WIDTH+2 divider cells that produce one quotient bit each
// and the output register. The receiver must take done when it comes.
// Write the six point registers only while no transaction is in flight.
module mobius_transform_three_points_core
    import mtp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [DATA_WIDTH-1:0]        cfg_data,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [DATA_WIDTH-1:0] point_real,
    input  wire logic signed [DATA_WIDTH-1:0] point_imag,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      image_real,
    output logic signed [DATA_WIDTH-1:0]      image_imag,
    output logic                              at_infinity,
    output logic                              clipped
);

    localparam int DW    = DATA_WIDTH;
    localparam int DIFW  = DW + 1;
    localparam int P1W   = 2 * DIFW;
    localparam int SUM1W = P1W + 1;
    localparam int MAG1W = P1W;
    localparam int P2W   = 2 * MAG1W;
    localparam int SUM2W = P2W + 2;
    localparam int NMW   = P2W + 1;
    localparam int DENW  = P2W + 1;
    localparam int QB    = DW + 2;
    localparam int YW    = NMW + FRAC_BITS + 1;
    localparam int HW    = YW - QB;
    localparam int RW    = ((HW > DENW) ? HW : DENW) + 1;
    localparam int ND    = (MAG1W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int SDL   = ND + 2 + QB;
    localparam int LAT   = 4 + ND + 2 + QB + 1;

    localparam logic [DW-1:0] SMAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QB-1:0] SMAX_Q = {{(QB-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [QB-1:0] SMIN_Q = {{(QB-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    // ---------------- helpers ----------------
    function automatic logic [DIFW-1:0] mag0(input logic [DIFW-1:0] v);
        return v[DIFW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MAG1W-1:0] mag1(input logic [SUM1W-1:0] v);
        logic [SUM1W-1:0] t;
        t = v[SUM1W-1] ? (~v + 1'b1) : v;
        return t[MAG1W-1:0];
    endfunction

    function automatic logic [SUM1W-1:0] sgn1(input logic [P1W-1:0] m, input logic s);
        logic [SUM1W-1:0] t;
        t = {1'b0, m};
        return s ? (~t + 1'b1) : t;
    endfunction

    function automatic logic [SUM2W-1:0] sgn2(input logic [P2W-1:0] m, input logic s);
        logic [SUM2W-1:0] t;
        t = SUM2W'(m);
        return s ? (~t + 1'b1) : t;
    endfunction

    // ---------------- configuration registers ----------------
    logic [DW-1:0] z0r_reg, z0i_reg, z1r_reg, z1i_reg, z2r_reg, z2i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z0r_reg <= '0;
            z0i_reg <= '0;
            z1r_reg <= '0;
            z1i_reg <= '0;
            z2r_reg <= '0;
            z2i_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZERO_RE: z0r_reg <= cfg_data;
                REG_ZERO_IM: z0i_reg <= cfg_data;
                REG_ONE_RE:  z1r_reg <= cfg_data;
                REG_ONE_IM:  z1i_reg <= cfg_data;
                REG_INF_RE:  z2r_reg <= cfg_data;
                REG_INF_IM:  z2i_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- valid and side-band pipelines ----------------
    logic      vld_reg  [LAT];
    mtp_side_t side_reg [SDL];
    mtp_side_t side_s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_s4_reg;
        for (int i = 1; i < SDL; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- S1: differences (index 0 = N, 1 = M) ----------------
    logic [DIFW-1:0] xr_reg [2];
    logic [DIFW-1:0] xi_reg [2];
    logic [DIFW-1:0] yr_reg [2];
    logic [DIFW-1:0] yi_reg [2];

    always_ff @(posedge clk)
    begin
        xr_reg[0] <= {point_real[DW-1], point_real} - {z0r_reg[DW-1], z0r_reg};
        xi_reg[0] <= {point_imag[DW-1], point_imag} - {z0i_reg[DW-1], z0i_reg};
        yr_reg[0] <= {z1r_reg[DW-1], z1r_reg} - {z2r_reg[DW-1], z2r_reg};
        yi_reg[0] <= {z1i_reg[DW-1], z1i_reg} - {z2i_reg[DW-1], z2i_reg};
        xr_reg[1] <= {point_real[DW-1], point_real} - {z2r_reg[DW-1], z2r_reg};
        xi_reg[1] <= {point_imag[DW-1], point_imag} - {z2i_reg[DW-1], z2i_reg};
        yr_reg[1] <= {z1r_reg[DW-1], z1r_reg} - {z0r_reg[DW-1], z0r_reg};
        yi_reg[1] <= {z1i_reg[DW-1], z1i_reg} - {z0i_reg[DW-1], z0i_reg};
    end

    // ---------------- S2..S4: complex products N and M ----------------
    logic [P1W-1:0]   prod_reg [2][4];
    logic             psgn_reg [2][4];
    logic [SUM1W-1:0] re_reg   [2];
    logic [SUM1W-1:0] im_reg   [2];
    logic [MAG1W-1:0] mre_reg  [2];
    logic [MAG1W-1:0] mim_reg  [2];

    for (genvar g = 0; g < 2; g++) begin : g_cplx
        // S2: magnitude products rr, ii, ri, ir
        always_ff @(posedge clk)
        begin
            prod_reg[g][0] <= mag0(xr_reg[g]) * mag0(yr_reg[g]);
            prod_reg[g][1] <= mag0(xi_reg[g]) * mag0(yi_reg[g]);
            prod_reg[g][2] <= mag0(xr_reg[g]) * mag0(yi_reg[g]);
            prod_reg[g][3] <= mag0(xi_reg[g]) * mag0(yr_reg[g]);
            psgn_reg[g][0] <= xr_reg[g][DIFW-1] ^ yr_reg[g][DIFW-1];
            psgn_reg[g][1] <= xi_reg[g][DIFW-1] ^ yi_reg[g][DIFW-1];
            psgn_reg[g][2] <= xr_reg[g][DIFW-1] ^ yi_reg[g][DIFW-1];
            psgn_reg[g][3] <= xi_reg[g][DIFW-1] ^ yr_reg[g][DIFW-1];
        end

        // S3: signed real and imaginary parts
        always_ff @(posedge clk)
        begin
            re_reg[g] <= sgn1(prod_reg[g][0], psgn_reg[g][0])
                       - sgn1(prod_reg[g][1], psgn_reg[g][1]);
            im_reg[g] <= sgn1(prod_reg[g][2], psgn_reg[g][2])
                       + sgn1(prod_reg[g][3], psgn_reg[g][3]);
        end

        // S4: magnitudes
        always_ff @(posedge clk)
        begin
            mre_reg[g] <= mag1(re_reg[g]);
            mim_reg[g] <= mag1(im_reg[g]);
        end
    end

    // S4 side-band: signs, zero denominator, numerator polarity
    always_ff @(posedge clk)
    begin
        side_s4_reg.inf   <= (re_reg[1] == '0) && (im_reg[1] == '0);
        side_s4_reg.pos_r <= !re_reg[0][SUM1W-1] && (re_reg[0] != '0);
        side_s4_reg.pos_i <= !im_reg[0][SUM1W-1] && (im_reg[0] != '0);
        side_s4_reg.sn_r  <= re_reg[0][SUM1W-1];
        side_s4_reg.sn_i  <= im_reg[0][SUM1W-1];
        side_s4_reg.sm_r  <= re_reg[1][SUM1W-1];
        side_s4_reg.sm_i  <= im_reg[1][SUM1W-1];
    end

    // ---------------- second products (digit pipelines) ----------------
    logic [P2W-1:0] p_mrmr, p_mimi, p_nrmr, p_nimi, p_nimr, p_nrmi;

    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_mrmr
        (.clk(clk), .a(mre_reg[1]), .b(mre_reg[1]), .p(p_mrmr));
    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_mimi
        (.clk(clk), .a(mim_reg[1]), .b(mim_reg[1]), .p(p_mimi));
    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_nrmr
        (.clk(clk), .a(mre_reg[0]), .b(mre_reg[1]), .p(p_nrmr));
    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_nimi
        (.clk(clk), .a(mim_reg[0]), .b(mim_reg[1]), .p(p_nimi));
    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_nimr
        (.clk(clk), .a(mim_reg[0]), .b(mre_reg[1]), .p(p_nimr));
    mtp_mul #(.AW(MAG1W), .BW(MAG1W), .DGW(MUL_DIGIT)) u_mul_nrmi
        (.clk(clk), .a(mre_reg[0]), .b(mim_reg[1]), .p(p_nrmi));

    // ---------------- S5: denominator and numerators ----------------
    logic [DENW-1:0]  den_reg;
    logic [SUM2W-1:0] num_reg [2];
    mtp_side_t        sd;

    assign sd = side_reg[ND-1];

    always_ff @(posedge clk)
    begin
        den_reg    <= DENW'(p_mrmr) + DENW'(p_mimi);
        num_reg[0] <= sgn2(p_nrmr, sd.sn_r ^ sd.sm_r) + sgn2(p_nimi, sd.sn_i ^ sd.sm_i);
        num_reg[1] <= sgn2(p_nimr, sd.sn_i ^ sd.sm_r) - sgn2(p_nrmi, sd.sn_r ^ sd.sm_i);
    end

    // ---------------- S6 and divider rows (lane 0 real, lane 1 imag) -------
    logic [RW-1:0]   rem_c [2][QB+1];
    logic [QB-1:0]   low_c [2][QB+1];
    logic [QB-1:0]   quo_c [2][QB+1];
    logic [DENW-1:0] den_c [2][QB+1];
    mtp_tag_t        tag_c [2][QB+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [SUM2W-1:0] nabs;
        logic [YW-1:0]    yv;
        logic [RW-1:0]    yhi;
        logic             over;

        // scaled magnitude, early range check on the top bits
        always_comb
        begin
            nabs = num_reg[l][SUM2W-1] ? (~num_reg[l] + 1'b1) : num_reg[l];
            yv   = {nabs[NMW-1:0], {(FRAC_BITS+1){1'b0}}};
            yhi  = RW'(yv[YW-1:QB]);
            over = (yhi >= RW'(den_reg));
        end

        always_ff @(posedge clk)
        begin
            rem_c[l][0]     <= over ? '0 : yhi;
            low_c[l][0]     <= yv[QB-1:0];
            quo_c[l][0]     <= '0;
            den_c[l][0]     <= den_reg;
            tag_c[l][0].neg <= num_reg[l][SUM2W-1];
            tag_c[l][0].big <= over;
        end

        for (genvar k = 0; k < QB; k++) begin : g_cell
            mtp_div_cell #(.RW(RW), .QB(QB), .DENW(DENW)) u_cell (
                .clk     (clk),
                .rem_in  (rem_c[l][k]),
                .low_in  (low_c[l][k]),
                .quo_in  (quo_c[l][k]),
                .den_in  (den_c[l][k]),
                .tag_in  (tag_c[l][k]),
                .rem_out (rem_c[l][k+1]),
                .low_out (low_c[l][k+1]),
                .quo_out (quo_c[l][k+1]),
                .den_out (den_c[l][k+1]),
                .tag_out (tag_c[l][k+1])
            );
        end
    end

    // ---------------- output stage: round, saturate, infinity code --------
    logic [DW-1:0] res_next [2];
    logic          clip_next [2];
    mtp_side_t     sf;

    assign sf = side_reg[SDL-1];

    for (genvar l = 0; l < 2; l++) begin : g_round
        logic [QB:0]   inc;
        logic [QB-1:0] rnd;
        logic          pos;

        always_comb
        begin
            inc = {1'b0, quo_c[l][QB]} + 1'b1;
            rnd = inc[QB:1];
            pos = (l == 0) ? sf.pos_r : sf.pos_i;
            if (sf.inf)
            begin
                res_next[l]  = pos ? SMAX : SMIN;
                clip_next[l] = 1'b0;
            end
            else if (tag_c[l][QB].neg)
            begin
                clip_next[l] = tag_c[l][QB].big || (rnd > SMIN_Q);
                res_next[l]  = clip_next[l] ? SMIN : (~rnd[DW-1:0] + 1'b1);
            end
            else
            begin
                clip_next[l] = tag_c[l][QB].big || (rnd > SMAX_Q);
                res_next[l]  = clip_next[l] ? SMAX : rnd[DW-1:0];
            end
        end
    end

    logic [DW-1:0] re_out_reg, im_out_reg;
    logic          inf_out_reg, clip_out_reg;

    always_ff @(posedge clk)
    begin
        re_out_reg   <= res_next[0];
        im_out_reg   <= res_next[1];
        inf_out_reg  <= sf.inf;
        clip_out_reg <= clip_next[0] || clip_next[1];
    end

    assign done        = vld_reg[LAT-1];
    assign image_real  = re_out_reg;
    assign image_imag  = im_out_reg;
    assign at_infinity = inf_out_reg;
    assign clipped     = clip_out_reg;

`ifndef SYNTH
    // infinity code and saturation never flagged together
    a_inf_not_clip: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(at_infinity && clipped))
        else $error("infinity and clip flagged together");

    // infinity code only carries full-scale parts
    a_inf_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (done && at_infinity) |->
            ((image_real == SMAX || image_real == SMIN) &&
             (image_imag == SMAX || image_imag == SMIN)))
        else $error("infinity result not full scale");

    // a clipped result has at least one saturated part
    a_clip_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |->
            (image_real == SMAX || image_real == SMIN ||
             image_imag == SMAX || image_imag == SMIN))
        else $error("clip flagged without saturated part");
`endif

endmodule
`default_nettype wire

@@ src/mtp_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_mul - pipelined unsigned multiplier
// Row of cells, one per digit of b: each cell multiplies a by one digit and
// adds the shifted partial product to the running sum from its neighbour.
// ----------------------------------------------------------------------------
module mtp_mul
    import mtp_pkg::*;
#(
    parameter int AW  = 66,
    parameter int BW  = 66,
    parameter int DGW = MUL_DIGIT
)
(
    input  wire logic             clk,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic      [AW+BW-1:0] p
);

    localparam int ND  = (BW + DGW - 1) / DGW;
    localparam int PW  = AW + BW;
    localparam int BPW = ND * DGW;

    logic [PW-1:0]  acc_reg [ND];
    logic [AW-1:0]  a_reg   [ND];
    logic [BPW-1:0] b_reg   [ND];

    for (genvar k = 0; k < ND; k++) begin : g_cell
        logic [AW-1:0]     a_in;
        logic [BPW-1:0]    b_in;
        logic [PW-1:0]     acc_in;
        logic [AW+DGW-1:0] part;

        if (k == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = BPW'(b);
            assign acc_in = '0;
        end
        else begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        // one digit of b against the whole of a
        assign part = a_in * b_in[k*DGW +: DGW];

        always_ff @(posedge clk)
        begin
            acc_reg[k] <= acc_in + (PW'(part) << (k * DGW));
            a_reg[k]   <= a_in;
            b_reg[k]   <= b_in;
        end
    end

    assign p = acc_reg[ND-1];

endmodule
`default_nettype wire

@@ src/mtp_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_div_cell - one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and appends the quotient bit; hands all to the next cell.
// ----------------------------------------------------------------------------
module mtp_div_cell
    import mtp_pkg::*;
#(
    parameter int RW   = 135,
    parameter int QB   = 34,
    parameter int DENW = 133
)
(
    input  wire logic            clk,
    input  wire logic [RW-1:0]   rem_in,
    input  wire logic [QB-1:0]   low_in,
    input  wire logic [QB-1:0]   quo_in,
    input  wire logic [DENW-1:0] den_in,
    input  wire mtp_tag_t        tag_in,
    output logic      [RW-1:0]   rem_out,
    output logic      [QB-1:0]   low_out,
    output logic      [QB-1:0]   quo_out,
    output logic      [DENW-1:0] den_out,
    output mtp_tag_t             tag_out
);

    logic [RW-1:0]   rem_reg;
    logic [QB-1:0]   low_reg;
    logic [QB-1:0]   quo_reg;
    logic [DENW-1:0] den_reg;
    mtp_tag_t        tag_reg;

    logic [RW-1:0] shifted;
    logic [RW-1:0] dext;
    logic [RW-1:0] diff;
    logic          fits;

    // trial subtract
    always_comb
    begin
        shifted = {rem_in[RW-2:0], low_in[QB-1]};
        dext    = RW'(den_in);
        diff    = shifted - dext;
        fits    = (shifted >= dext);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= fits ? diff : shifted;
        low_reg <= low_in << 1;
        quo_reg <= {quo_in[QB-2:0], fits};
        den_reg <= den_in;
        tag_reg <= tag_in;
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;
    assign tag_out = tag_reg;

endmodule
`default_nettype wire

@@ tb/tb_mobius_transform_three_points_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mobius_transform_three_points_core - self-checking bench for the Mobius map
// Drives points via start/busy, reprograms the three points between phases,
// and checks every image against a wide-integer predictor or typed result.
// ----------------------------------------------------------------------------
module tb_mobius_transform_three_points_core;
    import mtp_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_ONE = 1 <<< FB;
    // indexes beyond the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 250;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic inf;
        logic clip;
    } image_t;

    typedef struct {
        int phase;                 // 0: reset points, 1: directed points
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        bit typed;                 // expected result typed in below
        image_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [DW-1:0] point_real = '0;
    logic signed [DW-1:0] point_imag = '0;
    logic done;
    logic signed [DW-1:0] image_real;
    logic signed [DW-1:0] image_imag;
    logic at_infinity;
    logic clipped;

    // mirror of the six point registers
    logic signed [DW-1:0] pt_reg[6];
    image_t pending_images[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_inf = 0;
    int n_clip = 0;
    int n_phases = 0;
    bit no_gaps = 0;

    mobius_transform_three_points_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .point_real(point_real), .point_imag(point_imag),
        .done(done), .image_real(image_real), .image_imag(image_imag),
        .at_infinity(at_infinity), .clipped(clipped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // rounded, saturated num * 2^FB / den with den > 0
    function automatic logic signed [DW-1:0] div_round(input wide_t num, input wide_t den,
                                                       inout logic clip);
        wide_t mag;
        wide_t q;
        wide_t r;
        mag = (num < 0) ? -num : num;
        mag = mag <<< FB;
        q = mag / den;
        r = mag % den;
        if (2 * r >= den)
            q = q + 1;
        if (num < 0)
        begin
            if (q > -wide_t'(SMIN))
            begin
                clip = 1'b1;
                return SMIN;
            end
            return DW'(-q);
        end
        if (q > wide_t'(SMAX))
        begin
            clip = 1'b1;
            return SMAX;
        end
        return DW'(q);
    endfunction

    function automatic image_t map_point(input logic signed [DW-1:0] wr,
                                         input logic signed [DW-1:0] wi);
        wide_t ar, ai, br, bi, cr, ci, dr, di;
        wide_t nr, ni, mr, mi, den, nre, nim;
        image_t res;
        ar = wide_t'(wr) - wide_t'(pt_reg[REG_ZERO_RE]);
        ai = wide_t'(wi) - wide_t'(pt_reg[REG_ZERO_IM]);
        br = wide_t'(pt_reg[REG_ONE_RE]) - wide_t'(pt_reg[REG_INF_RE]);
        bi = wide_t'(pt_reg[REG_ONE_IM]) - wide_t'(pt_reg[REG_INF_IM]);
        cr = wide_t'(wr) - wide_t'(pt_reg[REG_INF_RE]);
        ci = wide_t'(wi) - wide_t'(pt_reg[REG_INF_IM]);
        dr = wide_t'(pt_reg[REG_ONE_RE]) - wide_t'(pt_reg[REG_ZERO_RE]);
        di = wide_t'(pt_reg[REG_ONE_IM]) - wide_t'(pt_reg[REG_ZERO_IM]);
        nr = ar * br - ai * bi;
        ni = ar * bi + ai * br;
        mr = cr * dr - ci * di;
        mi = cr * di + ci * dr;
        res.clip = 1'b0;
        // zero denominator: infinity code, sign taken from the numerator
        if (mr == 0 && mi == 0)
        begin
            res.re = (nr > 0) ? SMAX : SMIN;
            res.im = (ni > 0) ? SMAX : SMIN;
            res.inf = 1'b1;
            return res;
        end
        den = mr * mr + mi * mi;
        nre = nr * mr + ni * mi;
        nim = ni * mr - nr * mi;
        res.inf = 1'b0;
        res.re = div_round(nre, den, res.clip);
        res.im = div_round(nim, den, res.clip);
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx <= REG_INF_IM)
            pt_reg[idx] = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for the pipeline to empty before touching the registers
    task automatic wait_idle();
        while (pending_images.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one transaction; prediction is queued at the accepting edge
    task automatic send_point(input logic signed [DW-1:0] re, input logic signed [DW-1:0] im,
                              input bit typed, input image_t want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        point_real <= re;
        point_imag <= im;
        do
            @(posedge clk);
        while (busy);
        pending_images.insert(pending_images.size(), typed ? want : map_point(re, im));
        n_sent++;
    endtask

    function automatic logic signed [DW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return SMAX;
            1: return SMIN;
            2: return DW'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
            3: return '0;
            default: return DW'($urandom);
        endcase
    endfunction

    // point picked near the interesting places of the current map
    task automatic rand_point(output logic signed [DW-1:0] re, output logic signed [DW-1:0] im);
        case ($urandom_range(0, 9))
            0:
            begin
                re = pt_reg[REG_INF_RE];
                im = pt_reg[REG_INF_IM];
            end
            1:
            begin
                re = pt_reg[REG_ZERO_RE];
                im = pt_reg[REG_ZERO_IM];
            end
            2:
            begin
                re = pt_reg[REG_INF_RE] + DW'($signed($urandom_range(0, 64)) - 32);
                im = pt_reg[REG_INF_IM] + DW'($signed($urandom_range(0, 64)) - 32);
            end
            3:
            begin
                re = pt_reg[REG_ONE_RE];
                im = pt_reg[REG_ONE_IM];
            end
            4, 5:
            begin
                re = rand_coord();
                im = rand_coord();
            end
            default:
            begin
                re = DW'($urandom);
                im = DW'($urandom);
            end
        endcase
    endtask

    // result checker
    always @(posedge clk)
    begin
        image_t want;
        if (done)
        begin
            n_recv++;
            if (pending_images.size() == 0)
            begin
                $error("unexpected transaction: re=%0d im=%0d", image_real, image_imag);
                errors++;
            end
            else
            begin
                want = pending_images.pop_front();
                if (want.inf) n_inf++;
                if (want.clip) n_clip++;
                if (image_real !== want.re)
                begin
                    $error("image_real: expected %0d, got %0d", want.re, image_real);
                    errors++;
                end
                if (image_imag !== want.im)
                begin
                    $error("image_imag: expected %0d, got %0d", want.im, image_imag);
                    errors++;
                end
                if (at_infinity !== want.inf)
                begin
                    $error("at_infinity: expected %0b, got %0b", want.inf, at_infinity);
                    errors++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped: expected %0b, got %0b", want.clip, clipped);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        image_t none;
        logic signed [DW-1:0] re, im;
        int prev_phase;
        none = '{re: '0, im: '0, inf: 1'b0, clip: 1'b0};
        foreach (pt_reg[i]) pt_reg[i] = '0;

        // all points at the origin after reset: denominator always zero
        rows.insert(rows.size(), '{0, '0, '0, 1, '{SMIN, SMIN, 1'b1, 1'b0}});
        rows.insert(rows.size(), '{0, SMAX, SMAX, 1, '{SMIN, SMIN, 1'b1, 1'b0}});
        rows.insert(rows.size(), '{0, SMIN, SMIN, 1, '{SMIN, SMIN, 1'b1, 1'b0}});
        // map 2w/(w+1): z0 = 0, z1 = 1, z2 = -1
        rows.insert(rows.size(), '{1, '0, '0, 1, '{'0, '0, 1'b0, 1'b0}});
        rows.insert(rows.size(), '{1, Q_ONE, '0, 1, '{Q_ONE, '0, 1'b0, 1'b0}});
        rows.insert(rows.size(), '{1, -Q_ONE, '0, 1, '{SMIN, SMIN, 1'b1, 1'b0}});
        rows.insert(rows.size(), '{1, SMAX, SMAX, 0, none});
        rows.insert(rows.size(), '{1, SMIN, SMIN, 0, none});
        rows.insert(rows.size(), '{1, SMAX, SMIN, 0, none});
        rows.insert(rows.size(), '{1, SMIN, SMAX, 0, none});
        rows.insert(rows.size(), '{1, -Q_ONE + 1, '0, 0, none});   // just right of the pole
        rows.insert(rows.size(), '{1, -Q_ONE - 1, '0, 0, none});
        rows.insert(rows.size(), '{1, -Q_ONE, 1, 0, none});
        rows.insert(rows.size(), '{1, 1, 1, 0, none});
        rows.insert(rows.size(), '{1, 32'sh7fff, -32'sh1, 0, none});
        rows.insert(rows.size(), '{1, 32'h5555_5555, 32'hAAAA_AAAA, 0, none});
        rows.insert(rows.size(), '{1, 32'h0001_8000, 32'h0000_8000, 0, none});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // writes to indexes past the register file are dropped
        write_reg(REG_SPARE_A, 32'h1234_5678);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);

        prev_phase = 0;
        foreach (rows[k])
        begin
            row = rows[k];
            if (row.phase != prev_phase)
            begin
                @(negedge clk);
                start <= 1'b0;
                wait_idle();
                write_reg(REG_ZERO_RE, '0);
                write_reg(REG_ZERO_IM, '0);
                write_reg(REG_ONE_RE, Q_ONE);
                write_reg(REG_ONE_IM, '0);
                write_reg(REG_INF_RE, -Q_ONE);
                write_reg(REG_INF_IM, '0);
                prev_phase = row.phase;
                n_phases++;
            end
            send_point(row.re, row.im, row.typed, row.want);
        end

        // random phases, each with its own three points
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            @(negedge clk);
            start <= 1'b0;
            wait_idle();
            for (int r = 0; r < 6; r++)
            begin
                if (ph == 0)
                    write_reg(r[CFG_IDX_W-1:0], (r % 2) ? SMIN : SMAX);
                else if (ph == 1)
                    write_reg(r[CFG_IDX_W-1:0], (r % 2) ? SMAX : SMIN);
                else
                    write_reg(r[CFG_IDX_W-1:0], rand_coord());
            end
            // coincident points now and then
            if (ph == 3)
            begin
                write_reg(REG_ONE_RE, pt_reg[REG_ZERO_RE]);
                write_reg(REG_ONE_IM, pt_reg[REG_ZERO_IM]);
            end
            else if (ph == 4)
            begin
                write_reg(REG_ONE_RE, pt_reg[REG_INF_RE]);
                write_reg(REG_ONE_IM, pt_reg[REG_INF_IM]);
            end
            n_phases++;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                rand_point(re, im);
                send_point(re, im, 1'b0, none);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        wait_idle();

        $display("%0d points sent over %0d point settings, %0d results checked",
                 n_sent, n_phases, n_recv);
        $display("%0d at infinity, %0d saturated", n_inf, n_clip);
        if (errors == 0 && pending_images.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
